### rtl/core/sample_delta_encoder_core_defines.svh
// ----------------------------------------------------------------------------
// sample delta encoder assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef SAMPLE_DELTA_ENCODER_CORE_DEFINES_SVH
`define SAMPLE_DELTA_ENCODER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SDE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sde_pkg.sv
// ----------------------------------------------------------------------------
// sde_pkg
// types and constants shared by the sample delta encoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sde_pkg;

  localparam int unsigned CH_W         = 5;
  localparam int unsigned SMP_W        = 16;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned PBITS_W      = 5;
  localparam int unsigned IN_TDATA_W   = 24;
  localparam int unsigned OUT_TDATA_W  = 32;

  localparam int unsigned LSB_BITS_DEF = 4;
  localparam int unsigned CHANNELS_DEF = 32;

  localparam logic [PBITS_W-1:0] RAW_PBITS = 5'd16;
  localparam logic [LEN_W-1:0]   RAW_LCODE = 4'd0;

  // lookup stage status toward the delta stage
  typedef struct packed {
    logic valid;
    logic ref_live;
  } lookup_ctl_t;

  // delta stage status toward the token stage
  typedef struct packed {
    logic valid;
    logic raw;
  } delta_ctl_t;

  typedef struct packed {
    logic               compressed;
    logic [LEN_W-1:0]   length_code;
    logic [SMP_W-1:0]   payload;
    logic [PBITS_W-1:0] payload_bits;
  } token_t;

endpackage

### rtl/core/sde_ref_store.sv
// ----------------------------------------------------------------------------
// sde_ref_store
// per-channel reference memory, read and rewritten when a word is accepted
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sde_ref_store #(
  parameter int unsigned CHANNELS = sde_pkg::CHANNELS_DEF,
  parameter int unsigned IDX_W    = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [sde_pkg::CH_W-1:0]     channel,
  input  logic [sde_pkg::SMP_W-1:0]    sample,
  output sde_pkg::lookup_ctl_t         ctl,
  output logic [sde_pkg::SMP_W-1:0]    ref_sample,
  output logic [sde_pkg::SMP_W-1:0]    sample_q
);

  localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

  logic [sde_pkg::SMP_W-1:0]      mem [CHANNELS];
  logic [CHANNELS-1:0]            vld;
  logic [IDX_W+sde_pkg::CH_W-1:0] ch_ext;
  logic [IDX_W-1:0]               idx;
  logic                           in_range;
  logic                           take;
  logic                           valid;
  logic                           ref_live;

  assign ch_ext   = {{IDX_W{1'b0}}, channel};
  assign idx      = ch_ext[IDX_W-1:0];
  assign in_range = {2'b00, channel} < CH_LIMIT;
  assign take     = adv && in_valid;
  assign ctl      = '{valid: valid, ref_live: ref_live};

  // read old contents, then store the new sample as the reference
  always_ff @(posedge clk) begin
    if (take) begin
      ref_sample <= mem[idx];
      sample_q   <= sample;
      ref_live   <= in_range && vld[idx];
      if (in_range) begin
        mem[idx] <= sample;
      end
    end
  end

  // entries never written are flagged not live, so the delta stage compares against zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_valid;
      if (in_valid && in_range) begin
        vld[idx] <= 1'b1;
      end
    end
  end

endmodule

### rtl/core/sde_delta_stage.sv
// ----------------------------------------------------------------------------
// sde_delta_stage
// xor against the reference and decide raw versus compressed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sde_delta_stage #(
  parameter int unsigned LSB_BITS = sde_pkg::LSB_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  sde_pkg::lookup_ctl_t         ctl_in,
  input  logic [sde_pkg::SMP_W-1:0]    ref_sample,
  input  logic [sde_pkg::SMP_W-1:0]    sample,
  output sde_pkg::delta_ctl_t          ctl_out,
  output logic [LSB_BITS-1:0]          low,
  output logic [sde_pkg::SMP_W-1:0]    sample_q
);

  logic [sde_pkg::SMP_W-1:0] ref_eff;
  logic [sde_pkg::SMP_W-1:0] diff;
  logic                      raw;
  logic                      raw_flag;
  logic                      valid;

  assign ref_eff = ctl_in.ref_live ? ref_sample : '0;
  assign diff    = sample ^ ref_eff;
  // any change above the low bits (sign included) forces a raw token
  assign raw     = |diff[sde_pkg::SMP_W-1:LSB_BITS];
  assign ctl_out = '{valid: valid, raw: raw_flag};

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_flag <= raw;
      low      <= diff[LSB_BITS-1:0];
      sample_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= ctl_in.valid;
    end
  end

endmodule

### rtl/core/sde_token_stage.sv
// ----------------------------------------------------------------------------
// sde_token_stage
// bit length of the low difference and the registered output token
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sde_token_stage #(
  parameter int unsigned LSB_BITS = sde_pkg::LSB_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  sde_pkg::delta_ctl_t          ctl_in,
  input  logic [LSB_BITS-1:0]          low,
  input  logic [sde_pkg::SMP_W-1:0]    sample,
  output logic                         tok_valid,
  output sde_pkg::token_t              tok
);

  logic [sde_pkg::PBITS_W-1:0] nbits;
  logic [sde_pkg::PBITS_W-1:0] nbits_m1;
  sde_pkg::token_t             tok_next;

  // highest set bit decides the length, zero difference still takes one bit
  always_comb begin
    nbits = sde_pkg::PBITS_W'(1);
    for (int i = 1; i < LSB_BITS; i++) begin
      if (low[i]) begin
        nbits = sde_pkg::PBITS_W'(i + 1);
      end
    end
  end

  assign nbits_m1 = nbits - 1'b1;

  always_comb begin
    if (ctl_in.raw) begin
      tok_next.compressed   = 1'b0;
      tok_next.length_code  = sde_pkg::RAW_LCODE;
      tok_next.payload      = sample;
      tok_next.payload_bits = sde_pkg::RAW_PBITS;
    end else begin
      tok_next.compressed   = 1'b1;
      tok_next.length_code  = nbits_m1[sde_pkg::LEN_W-1:0];
      tok_next.payload      = {{(sde_pkg::SMP_W-LSB_BITS){1'b0}}, low};
      tok_next.payload_bits = nbits;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (adv) begin
      tok_valid <= ctl_in.valid;
    end
  end

endmodule

### rtl/core/sample_delta_encoder_core.sv
// ----------------------------------------------------------------------------
// sample_delta_encoder_core
// per-channel delta token encoder for a signed 16-bit sample stream
// ----------------------------------------------------------------------------
// Every accepted word yields exactly one token, presented on the master side
// once it has passed the three register stages (the first loading on the
// edge that accepts the word), and a new word is taken every cycle while the
// output register is empty or being drained, so the sustained rate is one
// word per clock. The channel's reference is read and the new sample written
// back in the accept cycle, so back-to-back words on one channel need no
// forwarding. The three register stages (lookup, delta, token) advance
// together; a stall on the output holds all of them and drops s_tready.
// References start at zero after reset without a clearing pass, through one
// valid bit per channel; channel numbers at or above CHANNELS compare
// against zero and are not stored.
`timescale 1ns / 1ps

`include "sample_delta_encoder_core_defines.svh"

module sample_delta_encoder_core #(
  parameter int unsigned LSB_BITS = sde_pkg::LSB_BITS_DEF,
  parameter int unsigned CHANNELS = sde_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [sde_pkg::IN_TDATA_W-1:0]      s_tdata,  // channel, sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [sde_pkg::OUT_TDATA_W-1:0]     m_tdata,  // length_code, payload, payload_bits
  output logic                                m_tuser   // compressed
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                         adv;
  logic [sde_pkg::CH_W-1:0]     channel;
  logic [sde_pkg::SMP_W-1:0]    sample;

  sde_pkg::lookup_ctl_t         lk_ctl;
  logic [sde_pkg::SMP_W-1:0]    lk_ref;
  logic [sde_pkg::SMP_W-1:0]    lk_sample;

  sde_pkg::delta_ctl_t          dl_ctl;
  logic [LSB_BITS-1:0]          dl_low;
  logic [sde_pkg::SMP_W-1:0]    dl_sample;

  logic                         tok_valid;
  sde_pkg::token_t              tok;

  assign channel  = s_tdata[sde_pkg::CH_W-1:0];
  assign sample   = s_tdata[sde_pkg::CH_W+sde_pkg::SMP_W-1:sde_pkg::CH_W];

  // whole pipeline moves when the output register can take a word
  assign adv      = !tok_valid || m_tready;
  assign s_tready = adv;

  sde_ref_store #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (s_tvalid),
    .channel    (channel),
    .sample     (sample),
    .ctl        (lk_ctl),
    .ref_sample (lk_ref),
    .sample_q   (lk_sample)
  );

  sde_delta_stage #(
    .LSB_BITS (LSB_BITS)
  ) u_delta (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctl_in     (lk_ctl),
    .ref_sample (lk_ref),
    .sample     (lk_sample),
    .ctl_out    (dl_ctl),
    .low        (dl_low),
    .sample_q   (dl_sample)
  );

  sde_token_stage #(
    .LSB_BITS (LSB_BITS)
  ) u_token (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (dl_ctl),
    .low       (dl_low),
    .sample    (dl_sample),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  assign m_tvalid = tok_valid;
  assign m_tuser  = tok.compressed;
  assign m_tdata  = {
    {(sde_pkg::OUT_TDATA_W-sde_pkg::LEN_W-sde_pkg::SMP_W-sde_pkg::PBITS_W){1'b0}},
    tok.payload_bits, tok.payload, tok.length_code
  };

  `SDE_ASSERT_SAME(a_raw_fixed_len, tok_valid && !tok.compressed,
    tok.payload_bits == sde_pkg::RAW_PBITS && tok.length_code == sde_pkg::RAW_LCODE,
    "raw token with wrong length fields")

  `SDE_ASSERT_SAME(a_comp_fits, tok_valid && tok.compressed,
    tok.payload_bits <= sde_pkg::PBITS_W'(LSB_BITS) && tok.payload_bits != '0 &&
    (tok.payload >> tok.payload_bits) == '0 &&
    tok.length_code == sde_pkg::LEN_W'(tok.payload_bits - 1'b1),
    "compressed token payload exceeds its length")

  `SDE_ASSERT_SAME(a_stall_source, !s_tready, tok_valid && !m_tready,
    "input stalled without an output stall")

  `SDE_ASSERT_NEXT(a_held_token, tok_valid && !m_tready,
    tok_valid && $stable(tok) && $stable(dl_ctl),
    "pipeline moved while output stalled")

endmodule

### tb/tb_sample_delta_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_sample_delta_encoder_core
// drives channel/sample words into the delta encoder, predicts each token
// from a per-channel copy of the reference samples and checks every token
// in order, under several idle/stall mixes and one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sample_delta_encoder_core;

  import sde_pkg::*;

  localparam int unsigned LSB_BITS  = LSB_BITS_DEF;
  localparam int unsigned CHANNELS  = CHANNELS_DEF;
  localparam logic [SMP_W-1:0] LOW_MASK = SMP_W'((1 << LSB_BITS) - 1);
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // channel, sample
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // length_code, payload, payload_bits
  logic                   m_tuser;   // compressed

  sample_delta_encoder_core #(
    .LSB_BITS (LSB_BITS),
    .CHANNELS (CHANNELS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predictor state and stimulus shadow
  logic [SMP_W-1:0] ref_samples [CHANNELS];
  logic [SMP_W-1:0] last_sent   [CHANNELS];
  token_t           pending_tokens [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned holdoff_len;
  int unsigned error_count;
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic token_t encode_delta(input logic [CH_W-1:0] ch,
                                          input logic [SMP_W-1:0] smp);
    token_t           tok;
    logic [SMP_W-1:0] base;
    logic [SMP_W-1:0] diff;
    int unsigned      nbits;
    base = (ch < CHANNELS) ? ref_samples[ch] : '0;
    diff = smp ^ base;
    if ((diff & ~LOW_MASK) != '0) begin
      tok.compressed   = 1'b0;
      tok.length_code  = RAW_LCODE;
      tok.payload      = smp;
      tok.payload_bits = RAW_PBITS;
    end else begin
      // zero difference still counts as one bit
      nbits = 1;
      for (int b = 0; b < LSB_BITS; b++) begin
        if (diff[b]) nbits = b + 1;
      end
      tok.compressed   = 1'b1;
      tok.length_code  = LEN_W'(nbits - 1);
      tok.payload      = diff & LOW_MASK;
      tok.payload_bits = PBITS_W'(nbits);
    end
    if (ch < CHANNELS) ref_samples[ch] = smp;
    return tok;
  endfunction

  // input side: predict on every accepted word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      pending_tokens.push_back(encode_delta(s_tdata[CH_W-1:0], s_tdata[CH_W +: SMP_W]));
  end

  // output side: compare each token with the oldest prediction
  always @(posedge clk) begin
    token_t got;
    token_t exp_tok;
    if (!rst && m_tvalid && m_tready) begin
      got.compressed   = m_tuser;
      got.length_code  = m_tdata[LEN_W-1:0];
      got.payload      = m_tdata[LEN_W +: SMP_W];
      got.payload_bits = m_tdata[LEN_W+SMP_W +: PBITS_W];
      if (pending_tokens.size() == 0) begin
        error_count++;
        $display("%0t: unexpected token c=%0b lc=%0d p=%h pb=%0d", $time,
                 got.compressed, got.length_code, got.payload, got.payload_bits);
      end else begin
        exp_tok = pending_tokens.pop_front();
        if (got !== exp_tok) begin
          error_count++;
          $display("%0t: token mismatch exp c=%0b lc=%0d p=%h pb=%0d got c=%0b lc=%0d p=%h pb=%0d",
                   $time, exp_tok.compressed, exp_tok.length_code, exp_tok.payload,
                   exp_tok.payload_bits, got.compressed, got.length_code, got.payload,
                   got.payload_bits);
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin : receiver
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_len != 0) begin
        m_tready <= 1'b0;
        repeat (holdoff_len) @(posedge clk);
        holdoff_len = 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[sample_delta_encoder_core] ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [CH_W-1:0] ch, input logic [SMP_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-CH_W-SMP_W){1'b0}}, smp, ch};
    last_sent[ch] = smp;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random_word();
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] smp;
    int unsigned      mode;
    ch   = CH_W'($urandom_range(CHANNELS - 1));
    mode = $urandom_range(99);
    if (mode < 50)
      smp = last_sent[ch] ^ SMP_W'($urandom_range(LOW_MASK));
    else if (mode < 70)
      smp = last_sent[ch] + SMP_W'($urandom_range(64)) - SMP_W'(32);
    else if (mode < 80)
      smp = last_sent[ch] ^ (SMP_W'(1) << $urandom_range(SMP_W - 1, LSB_BITS));
    else if (mode < 92)
      smp = SMP_W'($urandom);
    else begin
      case ($urandom_range(3))
        0:       smp = 16'h0000;
        1:       smp = 16'h7fff;
        2:       smp = 16'h8000;
        default: smp = 16'hffff;
      endcase
    end
    send_word(ch, smp);
  endtask

  task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    send_word(5'd0,  16'h0000);  // zero difference right after reset
    send_word(5'd0,  16'h0000);
    send_word(5'd31, 16'h000f);  // full low-bit difference
    send_word(5'd31, 16'h0008);  // xor 7, three bits
    send_word(5'd31, 16'h0009);  // xor 1, one bit
    send_word(5'd5,  16'h7fff);  // largest positive, raw
    send_word(5'd5,  16'h7ff0);  // only low bits change
    send_word(5'd5,  16'h8000);  // sign change, raw
    send_word(5'd6,  16'hffff);  // minus one against zero, raw
    send_word(5'd6,  16'hfffe);
    send_word(5'd6,  16'hfffe);
    send_word(5'd7,  16'h0010);  // lowest high bit differs
    send_word(5'd7,  16'h0011);
    send_word(5'd7,  16'h0013);  // back to back on one channel
    send_word(5'd7,  16'h0017);
    send_word(5'd7,  16'h0010);
    send_word(5'd16, 16'h8000);
    send_word(5'd16, 16'h800f);
    send_word(5'd16, 16'h7fff);  // sign change with equal low bits
    send_word(5'd0,  16'hffff);
  endtask

  task automatic test_random_stream();
    set_idling(0, 0);
    repeat (180) send_random_word();
    set_idling(78, 0);
    repeat (180) send_random_word();
    set_idling(0, 78);
    repeat (180) send_random_word();
    set_idling(33, 33);
    repeat (180) send_random_word();
  endtask

  task automatic test_output_holdoff();
    set_idling(0, 0);
    holdoff_len = 300;
    // input must back up once the pipeline fills
    repeat (30) send_random_word();
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_len    = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      ref_samples[i] = '0;
      last_sent[i]   = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_stream();
    test_output_holdoff();
    s_tvalid <= 1'b0;

    set_idling(0, 20);
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("[sample_delta_encoder_core] OK");
    else
      $display("[sample_delta_encoder_core] ERROR");
    $finish;
  end

endmodule
